// ----- design/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Shared codes and types for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_POST  = 2'd1,
    OP_WAIT  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_ATTACH_LIMIT = 3'd2,
    ST_TABLE_FULL   = 3'd3,
    ST_QUEUE_FULL   = 3'd4
  } status_t;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // result of one operation
  typedef struct packed {
    status_t    status;
    logic       wake_valid;
    logic [7:0] wake_pid;
    logic       caller_blocks;
  } result_t;

endpackage

// ----- design/cst_waitq.sv -----
// ----------------------------------------------------------------------------
// cst_waitq
// Waiter pid memory: one synchronous RAM, row per semaphore, one read and one
// write port, read data registered and held until the next read.
// ----------------------------------------------------------------------------
module cst_waitq #(
  parameter int unsigned NUM_SEMS    = 16,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PID_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              re,
  input  logic [((NUM_SEMS*QUEUE_DEPTH > 1) ? $clog2(NUM_SEMS*QUEUE_DEPTH) : 1)-1:0] raddr,
  output logic [PID_BITS-1:0]               rdata,
  input  logic                              we,
  input  logic [((NUM_SEMS*QUEUE_DEPTH > 1) ? $clog2(NUM_SEMS*QUEUE_DEPTH) : 1)-1:0] waddr,
  input  logic [PID_BITS-1:0]               wdata
);

  localparam int unsigned DEPTH = NUM_SEMS * QUEUE_DEPTH;

  logic [PID_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/counting_semaphore_table_top.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table_top
// Table of counting semaphores with per-entry FIFO wait queues.
// ----------------------------------------------------------------------------
// Usage: one operation enters on the s_axis channel (open, post, wait,
// close with key, initial count and caller pid) and one result leaves on
// m_axis (status, wake flag and pid, caller-blocks flag).
// Each transaction passes a lookup and an update stage: in the accepting cycle the key is
// matched against the valid entries and the head pid is read from the waiter
// RAM, then the update stage rewrites the entry and loads the output register.
// A new operation is accepted only after the previous one has left the update
// stage, as the entry update uses the registered read data of the waiter RAM.
// Reset clears all valid bits at once; no clearing pass is needed, and the
// entry fields are written in full when open creates an entry.
// When the receiver stalls, the result holds in the output register; the
// next operation may be accepted and worked through, and waits in the update
// stage until the output register is free.
// ----------------------------------------------------------------------------
module counting_semaphore_table_top
  import cst_pkg::*;
#(
  parameter int unsigned NUM_SEMS    = 16,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PID_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [33:2] sem_key, [49:34] init_value, [57:50] caller_pid
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [3] wake_valid, [11:4] wake_pid, [12] caller_blocks
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned IW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned AW = (NUM_SEMS * QUEUE_DEPTH > 1) ?
                               $clog2(NUM_SEMS * QUEUE_DEPTH) : 1;

  // entry state
  logic [NUM_SEMS-1:0] valid;
  logic [KEY_W-1:0]    keys   [NUM_SEMS];
  logic [COUNT_W-1:0]  counts [NUM_SEMS];
  logic [CW-1:0]       attach [NUM_SEMS];
  logic [CW-1:0]       fill   [NUM_SEMS];
  logic [QW-1:0]       head   [NUM_SEMS];

  // stage 1: lookup
  logic               busy;
  op_t                op_q;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] init_q;
  logic [PID_BITS-1:0] pid_q;
  logic               hit_q, free_ok_q;
  logic [IW-1:0]      idx_q, free_q;

  logic              hit, free_ok;
  logic [IW-1:0]     hit_idx, free_idx;
  logic [AW-1:0]     raddr;
  logic [PID_BITS-1:0] rdata;

  // stage 2: update
  logic          wq_we;
  logic [AW-1:0] wq_waddr;
  logic          do_upd;
  logic [IW-1:0] e;
  logic          e_ok;
  result_t       res;
  logic [QW-1:0] slot;
  logic [SW-1:0] slot_sum;
  logic [QW-1:0] head_inc;

  // key match and free search over the valid bits (lowest index wins)
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == s_axis_tdata[33:2]) begin
        hit = 1'b1; hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_ok = 1'b1; free_idx = IW'(i);
      end
    end
  end

  assign raddr = AW'(hit_idx) * AW'(QUEUE_DEPTH) + AW'(head[hit_idx]);

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !busy;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  cst_waitq #(.NUM_SEMS(NUM_SEMS), .QUEUE_DEPTH(QUEUE_DEPTH),
              .PID_BITS(PID_BITS)) u_waitq (
    .clk   (clk),
    .re    (acc),
    .raddr (raddr),
    .rdata (rdata),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (pid_q)
  );

  assign do_upd = busy && out_free;
  assign e      = hit_q ? idx_q : free_q;
  assign e_ok   = hit_q || (op_q == OP_OPEN && free_ok_q);

  // tail slot and next head, wrapped by compare rather than modulo
  assign slot_sum = SW'(head[e]) + SW'(fill[e]);
  assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
                                                   : QW'(slot_sum);
  assign head_inc = (head[e] == QW'(QUEUE_DEPTH - 1)) ? '0 : head[e] + QW'(1);
  assign wq_waddr = AW'(e) * AW'(QUEUE_DEPTH) + AW'(slot);

  always_comb begin
    res   = '{status: ST_OK, wake_valid: 1'b0, wake_pid: '0, caller_blocks: 1'b0};
    wq_we = 1'b0;
    if (!e_ok) begin
      res.status = (op_q == OP_OPEN) ? ST_TABLE_FULL : ST_NOT_FOUND;
    end else begin
      case (op_q)
        OP_OPEN: begin
          if (hit_q && attach[e] >= CW'(QUEUE_DEPTH)) res.status = ST_ATTACH_LIMIT;
        end
        OP_POST: begin
          if (fill[e] != '0) begin
            res.wake_valid = 1'b1;
            res.wake_pid   = 8'(rdata);
          end
        end
        OP_WAIT: begin
          if (counts[e] == '0) begin
            if (fill[e] >= CW'(QUEUE_DEPTH)) res.status = ST_QUEUE_FULL;
            else begin
              res.caller_blocks = 1'b1;
              wq_we = do_upd;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control and entry update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; m_axis_tvalid <= 1'b0; valid <= '0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (acc) busy <= 1'b1;
      if (do_upd) begin
        busy <= 1'b0;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {3'd0, res.caller_blocks, res.wake_pid, res.wake_valid,
                          res.status};
        if (e_ok) begin
          case (op_q)
            OP_OPEN: begin
              if (!hit_q) begin
                valid[e] <= 1'b1; keys[e] <= key_q; counts[e] <= init_q;
                attach[e] <= CW'(1); fill[e] <= '0; head[e] <= '0;
              end else if (attach[e] < CW'(QUEUE_DEPTH)) begin
                attach[e] <= attach[e] + CW'(1);
              end
            end
            OP_POST: begin
              if (fill[e] != '0) begin
                head[e] <= head_inc;
                fill[e] <= fill[e] - CW'(1);
              end else if (counts[e] != COUNT_MAX) begin
                counts[e] <= counts[e] + COUNT_W'(1);
              end
            end
            OP_WAIT: begin
              if (counts[e] != '0) counts[e] <= counts[e] - COUNT_W'(1);
              else if (res.caller_blocks) fill[e] <= fill[e] + CW'(1);
            end
            default: begin
              if (attach[e] <= CW'(1)) begin
                valid[e] <= 1'b0; attach[e] <= '0; fill[e] <= '0; head[e] <= '0;
              end else begin
                attach[e] <= attach[e] - CW'(1);
              end
            end
          endcase
        end
      end
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q      <= op_t'(s_axis_tdata[1:0]);
      key_q     <= s_axis_tdata[33:2];
      init_q    <= s_axis_tdata[49:34];
      pid_q     <= PID_BITS'(s_axis_tdata[57:50]);
      hit_q     <= hit;
      idx_q     <= hit_idx;
      free_ok_q <= free_ok;
      free_q    <= free_idx;
    end
  end

`ifndef SYNTHESIS
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    acc |=> busy) else $error("accept did not enter update stage");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("accepted while busy");
  a_wake_post: assert property (@(posedge clk) disable iff (rst)
    (do_upd && res.wake_valid) |-> op_q == OP_POST) else $error("wake outside post");
  a_block_wait: assert property (@(posedge clk) disable iff (rst)
    (do_upd && res.caller_blocks) |-> op_q == OP_WAIT) else $error("block outside wait");
`endif

endmodule
